@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the drive mode controller RTL.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("invariant check failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("next cycle check failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

@@ rtl/core/lrdmc_pkg.sv @@
// Types, constants and trajectory tables for the drive mode controller.
// Has no dependencies; lrdmc_if.sv and the top level import it.
`default_nettype none
package lrdmc_pkg;

   localparam int PROX_W      = 12;
   localparam int TARGET_W    = 10;
   localparam int SPEED_W     = 14;
   localparam int COUNT_W     = 4;
   localparam int THRESH_W    = 12;
   localparam int BIAS_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int PATH_LEN    = 19;
   localparam int TRAJ_IDX_W  = $clog2(PATH_LEN);
   localparam int CALC_W      = 16;
   localparam int PROX_SHIFT  = 4;

   // Reciprocal of ten in 19 fractional bits; exact for any 16-bit dividend.
   localparam int DIV10_SHIFT = 19;
   localparam logic [15:0] DIV10_MULT = 16'd52429;

   typedef logic [PROX_W-1:0]        prox_type;
   typedef logic [TARGET_W-1:0]      target_type;
   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic [COUNT_W-1:0]       count_type;
   typedef logic [TRAJ_IDX_W-1:0]    traj_idx_type;
   typedef logic [CSR_INDEX_W-1:0]   csr_index_type;
   typedef logic [CSR_DATA_W-1:0]    csr_data_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CRUISE_MODE        = 3'd0,
      CSR_OBSTACLE_THRESHOLD = 3'd1,
      CSR_SENSOR_BIAS        = 3'd2,
      CSR_HOLD_TICKS         = 3'd3,
      CSR_AVOID_TICKS        = 3'd4
   } csr_reg_type;

   typedef enum logic {
      CRUISE_TRAJECTORY = 1'b0,
      CRUISE_RANDOM     = 1'b1
   } cruise_mode_type;

   localparam cruise_mode_type   RST_CRUISE_MODE = CRUISE_RANDOM;
   localparam logic [THRESH_W-1:0] RST_THRESHOLD = 12'd300;
   localparam logic [BIAS_W-1:0]   RST_BIAS      = 8'd30;
   localparam count_type           RST_HOLD      = 4'd5;
   localparam count_type           RST_AVOID     = 4'd2;

   localparam speed_type TRAJ_LEFT [PATH_LEN] = '{
      14'sd600, 14'sd900, 14'sd900, 14'sd600, 14'sd700, 14'sd600, 14'sd300,
      14'sd300, 14'sd600, 14'sd600, 14'sd600, 14'sd300, 14'sd300, 14'sd300,
      14'sd600, 14'sd600, 14'sd600, 14'sd300, 14'sd300
   };
   localparam speed_type TRAJ_RIGHT [PATH_LEN] = '{
      14'sd600, 14'sd300, 14'sd300, 14'sd600, 14'sd700, 14'sd600, 14'sd900,
      14'sd900, 14'sd600, 14'sd600, 14'sd600, 14'sd900, 14'sd900, 14'sd900,
      14'sd600, 14'sd600, 14'sd600, 14'sd900, 14'sd900
   };

endpackage
`default_nettype wire

@@ rtl/core/lrdmc_if.sv @@
// Channel interfaces of the drive mode controller: sensor items, speed
// results and register writes. Depends on lrdmc_pkg.
`default_nettype none
interface lrdmc_req_if;
   import lrdmc_pkg::*;
   logic       valid;
   logic       ready;
   prox_type   prox_front_right;
   prox_type   prox_right_front;
   prox_type   prox_right_side;
   prox_type   prox_right_rear;
   prox_type   prox_left_front;
   prox_type   prox_front_left;
   target_type rand_target_left;
   target_type rand_target_right;
   modport source (output valid, prox_front_right, prox_right_front, prox_right_side,
                   prox_right_rear, prox_left_front, prox_front_left,
                   rand_target_left, rand_target_right, input ready);
   modport sink (input valid, prox_front_right, prox_right_front, prox_right_side,
                 prox_right_rear, prox_left_front, prox_front_left,
                 rand_target_left, rand_target_right, output ready);
endinterface

interface lrdmc_rsp_if;
   import lrdmc_pkg::*;
   logic      valid;
   logic      ready;
   speed_type speed_left;
   speed_type speed_right;
   logic      turn_right_led;
   logic      avoiding;
   modport source (output valid, speed_left, speed_right, turn_right_led, avoiding,
                   input ready);
   modport sink (input valid, speed_left, speed_right, turn_right_led, avoiding,
                 output ready);
endinterface

interface lrdmc_csr_if;
   import lrdmc_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/leader_robot_drive_mode_controller.sv @@
// Drive mode controller top level: obstacle avoidance over a cruise behavior.
// Depends on lrdmc_pkg, the channel interfaces in lrdmc_if.sv and assert_macros.svh.
//
//   channel   direction   carries
//   req_ch    in          six proximity readings, two random speed targets
//   rsp_ch    out         wheel speeds, turn LED, avoidance flag
//   csr_ch    in          register index and write data
//
// One item is accepted per cycle while no stalled result blocks it; its result
// is registered and shown on the next cycle. The longest path is the divide by
// ten of the random blend, one 16 by 16 constant multiply. Reset is synchronous
// and restores the register defaults. A stalled result holds the output register
// and blocks the next item only while rsp_ch.ready stays low. Register writes
// are always taken.
`include "assert_macros.svh"
`default_nettype none
module leader_robot_drive_mode_controller (
   input  wire          clock,
   input  wire          reset,
   lrdmc_req_if.sink    req_ch,
   lrdmc_rsp_if.source  rsp_ch,
   lrdmc_csr_if.sink    csr_ch
);
   import lrdmc_pkg::*;

   cruise_mode_type       cruise_mode_ff;
   logic [THRESH_W-1:0]   threshold_ff;
   logic [BIAS_W-1:0]     bias_ff;
   count_type             hold_ticks_ff;
   count_type             avoid_ticks_ff;

   speed_type    last_left_ff,  last_left_in;
   speed_type    last_right_ff, last_right_in;
   logic         in_avoid_ff,   in_avoid_in;
   count_type    hold_cnt_ff,   hold_cnt_in;
   count_type    avoid_cnt_ff,  avoid_cnt_in;
   traj_idx_type traj_idx_ff,   traj_idx_in;

   logic      rsp_valid_ff;
   speed_type rsp_left_ff;
   speed_type rsp_right_ff;
   logic      rsp_turn_ff;
   logic      rsp_avoid_ff;

   logic accept;
   prox_type front_max_a, front_max_b, front_max;
   logic enter, leave;
   count_type hold_base, avoid_base;

   logic [BIAS_W-1:0] v0, v1, v2, v4, v5;
   logic signed [CALC_W-1:0] diff, avoid_d, bias2, avoid_left, avoid_right;

   logic signed [CALC_W-1:0] num_left, num_right;
   speed_type blend_left, blend_right;

   function automatic speed_type div10_trunc(input logic signed [CALC_W-1:0] num);
      logic        neg;
      logic [CALC_W-1:0] mag;
      logic [31:0] prod;
      logic [SPEED_W-1:0] quo;
      neg  = num[CALC_W-1];
      mag  = neg ? CALC_W'(-num) : CALC_W'(num);
      prod = 32'(mag) * 32'(DIV10_MULT);
      quo  = {1'b0, prod[DIV10_SHIFT +: SPEED_W-1]};
      return neg ? speed_type'(-quo) : speed_type'(quo);
   endfunction

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_mode_ff <= RST_CRUISE_MODE;
         threshold_ff   <= RST_THRESHOLD;
         bias_ff        <= RST_BIAS;
         hold_ticks_ff  <= RST_HOLD;
         avoid_ticks_ff <= RST_AVOID;
      end else if (csr_ch.valid) begin
         case (csr_reg_type'(csr_ch.index))
            CSR_CRUISE_MODE:        cruise_mode_ff <= cruise_mode_type'(csr_ch.data[0]);
            CSR_OBSTACLE_THRESHOLD: threshold_ff   <= csr_ch.data[THRESH_W-1:0];
            CSR_SENSOR_BIAS:        bias_ff        <= csr_ch.data[BIAS_W-1:0];
            CSR_HOLD_TICKS:         hold_ticks_ff  <= csr_ch.data[COUNT_W-1:0];
            CSR_AVOID_TICKS:        avoid_ticks_ff <= csr_ch.data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      front_max_a = (req_ch.prox_front_right > req_ch.prox_right_front) ?
                    req_ch.prox_front_right : req_ch.prox_right_front;
      front_max_b = (req_ch.prox_left_front > req_ch.prox_front_left) ?
                    req_ch.prox_left_front : req_ch.prox_front_left;
      front_max   = (front_max_a > front_max_b) ? front_max_a : front_max_b;
      enter       = (front_max > threshold_ff) && !in_avoid_ff;
      leave       = !enter && (avoid_cnt_ff >= avoid_ticks_ff);
      hold_base   = leave ? '0 : hold_cnt_ff;
      avoid_base  = (enter || leave) ? '0 : avoid_cnt_ff;
   end

   // Braitenberg weights: -10,-10,-5,0,10,10 on the left wheel, negated on the right.
   always_comb begin
      v0 = req_ch.prox_front_right[PROX_W-1:PROX_SHIFT];
      v1 = req_ch.prox_right_front[PROX_W-1:PROX_SHIFT];
      v2 = req_ch.prox_right_side[PROX_W-1:PROX_SHIFT];
      v4 = req_ch.prox_left_front[PROX_W-1:PROX_SHIFT];
      v5 = req_ch.prox_front_left[PROX_W-1:PROX_SHIFT];
      diff = $signed(CALC_W'(v4) + CALC_W'(v5)) - $signed(CALC_W'(v0) + CALC_W'(v1));
      avoid_d = (diff <<< 3) + (diff <<< 1) - $signed((CALC_W'(v2) << 2) + CALC_W'(v2));
      bias2 = $signed(CALC_W'(bias_ff) << 1);
      avoid_left  = avoid_d + bias2;
      avoid_right = bias2 - avoid_d;
   end

   always_comb begin
      num_left  = $signed(CALC_W'(req_ch.rand_target_left) << 3)
                + ($signed(CALC_W'(last_left_ff)) <<< 1);
      num_right = $signed(CALC_W'(req_ch.rand_target_right) << 3)
                + ($signed(CALC_W'(last_right_ff)) <<< 1);
      blend_left  = div10_trunc(num_left);
      blend_right = div10_trunc(num_right);
   end

   always_comb begin
      in_avoid_in   = enter ? 1'b1 : (leave ? 1'b0 : in_avoid_ff);
      hold_cnt_in   = hold_base;
      avoid_cnt_in  = avoid_base;
      traj_idx_in   = traj_idx_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      if (in_avoid_in) begin
         last_left_in  = speed_type'(avoid_left);
         last_right_in = speed_type'(avoid_right);
         avoid_cnt_in  = avoid_base + 1'b1;
      end else if (hold_base >= hold_ticks_ff) begin
         if (cruise_mode_ff == CRUISE_RANDOM) begin
            last_left_in  = blend_left;
            last_right_in = blend_right;
         end else begin
            last_left_in  = TRAJ_LEFT[traj_idx_ff];
            last_right_in = TRAJ_RIGHT[traj_idx_ff];
            traj_idx_in   = (traj_idx_ff == traj_idx_type'(PATH_LEN - 1)) ?
                            '0 : traj_idx_ff + 1'b1;
         end
         hold_cnt_in = '0;
      end else begin
         hold_cnt_in = hold_base + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_left_ff  <= '0;
         last_right_ff <= '0;
         in_avoid_ff   <= 1'b0;
         hold_cnt_ff   <= '0;
         avoid_cnt_ff  <= '0;
         traj_idx_ff   <= '0;
      end else if (accept) begin
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         in_avoid_ff   <= in_avoid_in;
         hold_cnt_ff   <= hold_cnt_in;
         avoid_cnt_ff  <= avoid_cnt_in;
         traj_idx_ff   <= traj_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_left_ff  <= last_left_in;
         rsp_right_ff <= last_right_in;
         rsp_turn_ff  <= last_left_in > last_right_in;
         rsp_avoid_ff <= in_avoid_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.speed_left     = rsp_left_ff;
   assign rsp_ch.speed_right    = rsp_right_ff;
   assign rsp_ch.turn_right_led = rsp_turn_ff;
   assign rsp_ch.avoiding       = rsp_avoid_ff;

   `ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)
   `ASSERT_ALWAYS(a_flag_matches_state, clock, reset, !rsp_valid_ff || (rsp_avoid_ff == in_avoid_ff))
   `ASSERT_ALWAYS(a_traj_index_bound, clock, reset, traj_idx_ff < traj_idx_type'(PATH_LEN))
   `ASSERT_ALWAYS(a_cruise_avoid_cnt_clear, clock, reset, in_avoid_ff || (avoid_cnt_ff == '0))

endmodule
`default_nettype wire
